### hdl/sfcrc_pkg.sv
// Shared types, constants and the CRC-16-CCITT byte update for the sync-framed receiver.
// No dependencies; imported by every module of the block.
package sfcrc_pkg;

  localparam int MsgLen   = 16;
  localparam int PosW     = $clog2(MsgLen);
  localparam int IdxW     = 4;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;

  localparam logic [PosW-1:0] PosCrcLo = PosW'(MsgLen - 2);

  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncWord = 1'b0,
    CfgCrcSeed  = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OpByte       = 1'b0,
    OpDisconnect = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic [IdxW-1:0] byte_index;
    logic            last;
    logic            crc_ok;
  } out_word_t;

  function automatic logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
    c = c ^ {12'h000, c[7:4]};
    c = c ^ {c[3:0], 12'h000};
    c = c ^ {3'b000, c[7:0], 5'b00000};
    return c;
  endfunction

endpackage

### hdl/sfcrc_out_buf.sv
// Output register with a skid stage for result words of the sync-framed receiver.
// Depends on sfcrc_pkg for the result word type.
module sfcrc_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sfcrc_pkg::out_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sfcrc_pkg::out_word_t  out_data_o
);
  import sfcrc_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_word_t out_q;
  out_word_t skid_q;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

endmodule

### hdl/sync_framed_crc16_receiver_top.sv
// Top level of the sync-framed receiver with CRC-16-CCITT check.
// Depends on sfcrc_pkg and sfcrc_out_buf.
//
// Usage: input words carry a received UART byte or a link disconnect event.
// While idle, every byte except the sync word is dropped; the sync word opens
// a frame. The next MsgLen bytes each leave as one result word with their
// position; the final one has last set and crc_ok telling whether the CRC over
// the first MsgLen-2 bytes matches the little-endian CRC in the last two.
// A disconnect drops any partial frame and produces no word.
// Throughput: one input word per cycle while input ready is high; the CRC
// byte update is combinational between the frame state registers. A result
// word is registered in the output register, or in the skid stage on a stall.
// The output register and a one-word skid stage keep input ready high while a
// single result waits; input ready falls only once both are full, and rises
// again the cycle after the receiver takes a word.
// Configuration (sync word, CRC seed) is written through cfg_we_i at any edge;
// a new seed applies from the next frame start.
// Reset: idle, sync word 0x00, seed 0xFFFF, no pending result.
module sync_framed_crc16_receiver_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sfcrc_pkg::in_word_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output sfcrc_pkg::out_word_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sfcrc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfcrc_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import sfcrc_pkg::*;

  logic [7:0]      sync_q;
  logic [15:0]     seed_q;
  logic            receiving_q, receiving_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_lo_q, crc_lo_d;

  logic            accept;
  logic            res_valid;
  out_word_t       res;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= 8'h00;
      seed_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSyncWord: sync_q <= cfg_wdata_i[7:0];
        CfgCrcSeed:  seed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    receiving_d = receiving_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    crc_lo_d    = crc_lo_q;
    res_valid   = 1'b0;
    res.data_byte  = in_data_i.rx_byte;
    res.byte_index = IdxW'(pos_q);
    res.last       = 1'b0;
    res.crc_ok     = 1'b0;
    if (in_data_i.op == OpDisconnect) begin
      receiving_d = 1'b0;
    end else if (!receiving_q) begin
      if (in_data_i.rx_byte == sync_q) begin
        receiving_d = 1'b1;
        pos_d       = '0;
        crc_d       = seed_q;
      end
    end else begin
      res_valid = 1'b1;
      pos_d     = pos_q + 1'b1;
      if (pos_q < PosCrcLo) begin
        crc_d = crc_ccitt_byte(crc_q, in_data_i.rx_byte);
      end else if (pos_q == PosCrcLo) begin
        crc_lo_d = in_data_i.rx_byte;
      end else begin
        res.last    = 1'b1;
        res.crc_ok  = ({in_data_i.rx_byte, crc_lo_q} == crc_q);
        receiving_d = 1'b0;
        pos_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      pos_q       <= '0;
      crc_q       <= 16'hFFFF;
      crc_lo_q    <= 8'h00;
    end else if (accept) begin
      receiving_q <= receiving_d;
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      crc_lo_q    <= crc_lo_d;
    end
  end

  sfcrc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept && res_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/sfcrc_checker.sv
// Port-level checks for the sync-framed receiver, bound to its top level.
// Depends on sfcrc_pkg and sync_framed_crc16_receiver_top.
module sfcrc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input sfcrc_pkg::out_word_t  out_data_o
);
  import sfcrc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or dropped while stalled");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_ok |-> out_data_o.last)
    else $error("crc_ok set on a word that is not last");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.byte_index == IdxW'(MsgLen - 1))
    else $error("last word at wrong position");

  a_word_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result word without an accepted input word");

endmodule

bind sync_framed_crc16_receiver_top sfcrc_checker u_sfcrc_checker (.*);

### sim/tb_sync_framed_crc16_receiver_top.sv
// Testbench for sync_framed_crc16_receiver_top: framed, broken and noise byte streams under
// several sync/seed settings and handshake pressure, checked against a frame/CRC predictor.
// Depends on sfcrc_pkg and the RTL of the block.
module tb_sync_framed_crc16_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcrc_pkg::*;

  localparam int NumPhases   = 8;
  localparam int PhaseWords  = 106;
  localparam int SettleCycles = 4;

  class frame_predictor;
    logic [7:0]  sync_word;
    logic [15:0] frame_seed;
    bit          receiving;
    int unsigned frame_pos;
    logic [15:0] crc_acc;
    logic [7:0]  rx_crc_lo;
    out_word_t   words_due[$];
    int          errors;

    function new();
      sync_word  = 8'h00;
      frame_seed = 16'hffff;
      receiving  = 1'b0;
      frame_pos  = 0;
      crc_acc    = 16'hffff;
      rx_crc_lo  = 8'h00;
      errors     = 0;
    endfunction

    static function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
      return c;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [15:0] value);
      if (idx == CfgSyncWord) begin
        sync_word = value[7:0];
      end else begin
        frame_seed = value;
      end
    endfunction

    // Returns 1 when the word changes state or produces a result.
    function bit note_input(in_word_t w);
      out_word_t exp_word;
      bit        was_rx;
      was_rx = receiving;
      if (w.op == OpDisconnect) begin
        receiving = 1'b0;
        return was_rx;
      end
      if (!receiving) begin
        if (w.rx_byte == sync_word) begin
          receiving = 1'b1;
          frame_pos = 0;
          crc_acc   = frame_seed;
          return 1'b1;
        end
        return 1'b0;
      end
      exp_word.data_byte  = w.rx_byte;
      exp_word.byte_index = IdxW'(frame_pos);
      exp_word.last       = 1'b0;
      exp_word.crc_ok     = 1'b0;
      if (frame_pos < MsgLen - 2) begin
        crc_acc = crc_update(crc_acc, w.rx_byte);
        frame_pos++;
      end else if (frame_pos == MsgLen - 2) begin
        rx_crc_lo = w.rx_byte;
        frame_pos++;
      end else begin
        exp_word.last   = 1'b1;
        exp_word.crc_ok = ({w.rx_byte, rx_crc_lo} == crc_acc);
        receiving = 1'b0;
        frame_pos = 0;
      end
      words_due.push_back(exp_word);
      return 1'b1;
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_word;
      if (words_due.size() == 0) begin
        $error("unexpected result word %0h", got);
        errors++;
        return;
      end
      exp_word = words_due.pop_front();
      if (got.data_byte !== exp_word.data_byte) begin
        $error("data_byte: expected %0h, got %0h", exp_word.data_byte, got.data_byte);
        errors++;
      end
      if (got.byte_index !== exp_word.byte_index) begin
        $error("byte_index: expected %0d, got %0d", exp_word.byte_index, got.byte_index);
        errors++;
      end
      if (got.last !== exp_word.last) begin
        $error("last: expected %0b, got %0b", exp_word.last, got.last);
        errors++;
      end
      if (got.crc_ok !== exp_word.crc_ok) begin
        $error("crc_ok: expected %0b, got %0b", exp_word.crc_ok, got.crc_ok);
        errors++;
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_word_t            in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_word_t           out_data;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = '0;
  logic [CfgDataW-1:0] cfg_wdata   = '0;

  frame_predictor sb;
  int snd_idle   = 0;
  int rcv_stall  = 0;
  int live_words = 0;

  sync_framed_crc16_receiver_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (sb.note_input(w)) live_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(in_word_t'{op: OpByte, rx_byte: b});
  endtask

  task automatic send_disconnect();
    send_word(in_word_t'{op: OpDisconnect, rx_byte: 8'($urandom)});
  endtask

  // corrupt_at/cut_at of -1 leave the frame intact.
  task automatic send_frame(input int corrupt_at, input int cut_at, input bit edge_payload);
    logic [15:0] crc;
    logic [7:0]  b;
    if (sb.receiving) send_disconnect();
    send_byte(sb.sync_word);
    crc = sb.frame_seed;
    for (int i = 0; i < MsgLen; i++) begin
      if (i == cut_at) begin
        send_disconnect();
        return;
      end
      if (i < MsgLen - 2) begin
        if (edge_payload && i == 0) b = 8'h00;
        else if (edge_payload && i == 1) b = 8'hff;
        else if ((edge_payload && i == 2) || $urandom_range(0, 9) == 0) b = sb.sync_word;
        else b = 8'($urandom);
        crc = frame_predictor::crc_update(crc, b);
      end else if (i == MsgLen - 2) begin
        b = crc[7:0];
      end else begin
        b = crc[15:8];
      end
      if (i == corrupt_at) b ^= 8'(1 << $urandom_range(0, 7));
      send_byte(b);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int          r;
    logic [7:0]  sync_val;
    logic [15:0] seed_val;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      case (phase % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 78; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 78; end
        default: begin snd_idle = 36; rcv_stall = 36; end
      endcase
      if (phase == 0) begin
        sync_val = 8'h00;
        seed_val = 16'hffff;
      end else if (phase == 1) begin
        sync_val = 8'hff;
        seed_val = 16'h0000;
      end else begin
        sync_val = 8'($urandom);
        seed_val = 16'($urandom);
      end
      write_reg(CfgSyncWord, {8'($urandom), sync_val});
      write_reg(CfgCrcSeed, seed_val);

      if (phase == 0) begin
        send_disconnect();
        send_byte(8'hff);
        send_frame(-1, -1, 1'b1);
        send_frame(-1, 2, 1'b0);
        send_disconnect();
      end

      live_words = 0;
      while (live_words < PhaseWords) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_frame(-1, -1, 1'b0);
        end else if (r < 75) begin
          send_frame($urandom_range(0, MsgLen - 1), -1, 1'b0);
        end else if (r < 83) begin
          send_frame(-1, $urandom_range(0, MsgLen - 1), 1'b0);
        end else if (r < 95) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
          send_disconnect();
        end
      end
      in_valid <= 1'b0;
      @(posedge clk_i);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
